### design/u8dec_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package u8dec_pkg;

	localparam int unsigned CpWidth = 21;
	localparam int unsigned RemWidth = 2;

	localparam logic [CpWidth-1:0] CpReplacement = 21'h00FFFD;

	// Lead byte classes, matched as (byte & mask) == pattern.
	localparam logic [7:0] Lead1Mask = 8'h80;
	localparam logic [7:0] Lead1Pat = 8'h00;
	localparam logic [7:0] Lead2Mask = 8'hE0;
	localparam logic [7:0] Lead2Pat = 8'hC0;
	localparam logic [7:0] Lead3Mask = 8'hF0;
	localparam logic [7:0] Lead3Pat = 8'hE0;
	localparam logic [7:0] Lead4Mask = 8'hF8;
	localparam logic [7:0] Lead4Pat = 8'hF0;

	// Payload masks for lead and following bytes.
	localparam logic [7:0] Pay2Mask = 8'h1F;
	localparam logic [7:0] Pay3Mask = 8'h0F;
	localparam logic [7:0] Pay4Mask = 8'h07;
	localparam logic [7:0] ContMask = 8'h3F;

	typedef struct packed {
		logic [RemWidth-1:0] rem;
		logic [CpWidth-1:0] acc;
	} u8dec_state_t;

	typedef struct packed {
		logic valid;
		logic [CpWidth-1:0] code_point;
		logic replaced;
		logic end_of_string;
	} u8dec_res_t;

endpackage
`default_nettype wire

### design/u8dec_decode.sv
// Combinational decode step: one byte against the open-sequence state.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_decode (
	input wire u8dec_pkg::u8dec_state_t state,
	input wire [7:0] byte_in,
	input wire last_byte,
	output u8dec_pkg::u8dec_state_t state_next,
	output u8dec_pkg::u8dec_res_t res
);

	logic is_l1, is_l2, is_l3, is_l4;
	logic [u8dec_pkg::CpWidth-1:0] acc_shift;
	logic [u8dec_pkg::RemWidth-1:0] rem_dec;

	assign is_l1 = (byte_in & u8dec_pkg::Lead1Mask) == u8dec_pkg::Lead1Pat;
	assign is_l2 = (byte_in & u8dec_pkg::Lead2Mask) == u8dec_pkg::Lead2Pat;
	assign is_l3 = (byte_in & u8dec_pkg::Lead3Mask) == u8dec_pkg::Lead3Pat;
	assign is_l4 = (byte_in & u8dec_pkg::Lead4Mask) == u8dec_pkg::Lead4Pat;

	// Following bytes are not checked for the continuation pattern.
	assign acc_shift = {state.acc[u8dec_pkg::CpWidth-7:0],
		byte_in[5:0] & u8dec_pkg::ContMask[5:0]};
	assign rem_dec = state.rem - 2'd1;

	always_comb begin
		state_next = state;
		res.valid = 1'b0;
		res.code_point = '0;
		res.replaced = 1'b0;
		res.end_of_string = last_byte;
		if (state.rem == '0) begin
			if (is_l1) begin
				res.valid = 1'b1;
				res.code_point = {13'd0, byte_in};
			end else if (!(is_l2 || is_l3 || is_l4)) begin
				res.valid = 1'b1;
				res.code_point = u8dec_pkg::CpReplacement;
				res.replaced = 1'b1;
			end else if (last_byte) begin
				// String ends right after a multi-byte lead.
				res.valid = 1'b1;
				res.code_point = u8dec_pkg::CpReplacement;
				res.replaced = 1'b1;
			end else if (is_l2) begin
				state_next.acc = {16'd0, byte_in[4:0] & u8dec_pkg::Pay2Mask[4:0]};
				state_next.rem = 2'd1;
			end else if (is_l3) begin
				state_next.acc = {17'd0, byte_in[3:0] & u8dec_pkg::Pay3Mask[3:0]};
				state_next.rem = 2'd2;
			end else begin
				state_next.acc = {18'd0, byte_in[2:0] & u8dec_pkg::Pay4Mask[2:0]};
				state_next.rem = 2'd3;
			end
		end else begin
			state_next.rem = rem_dec;
			state_next.acc = acc_shift;
			if (rem_dec == '0) begin
				res.valid = 1'b1;
				res.code_point = acc_shift;
				state_next.acc = '0;
			end else if (last_byte) begin
				// Truncated sequence: drop it and report one replacement.
				res.valid = 1'b1;
				res.code_point = u8dec_pkg::CpReplacement;
				res.replaced = 1'b1;
				state_next.rem = '0;
				state_next.acc = '0;
			end
		end
	end

endmodule
`default_nettype wire

### design/u8dec_outreg.sv
// Output register of the decoder with stream-side handshake.
`timescale 1ns / 1ps
`default_nettype none
module u8dec_outreg (
	input wire clk,
	input wire arst_n,
	input wire load,
	input wire u8dec_pkg::u8dec_res_t res,
	output logic free,
	output logic m_axis_tvalid,
	input wire m_axis_tready,
	output logic [23:0] m_axis_tdata,
	output logic m_axis_tuser,
	output logic m_axis_tlast
);

	logic valid_q;
	logic [u8dec_pkg::CpWidth-1:0] cp_q;
	logic rep_q;
	logic eos_q;

	// The register can take a new result when empty or when drained this cycle.
	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			cp_q <= res.code_point;
			rep_q <= res.replaced;
			eos_q <= res.end_of_string;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata = {3'd0, cp_q};
	assign m_axis_tuser = rep_q;
	assign m_axis_tlast = eos_q;

endmodule
`default_nettype wire

### design/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decode step, output register.
//
//   channel  dir  tdata (low bit up)           tuser        tlast
//   s_axis   in   byte_in[7:0]                 -            last_byte
//   m_axis   out  code_point[20:0], 3'b0 pad   replaced     end_of_string
//
// One byte is taken per cycle while s_axis_tready is high. A byte waits in the input
// register, where the decode step runs against the open-sequence state, and its
// result (if any) lands in the output register when the byte leaves that register.
// Bytes that open or continue a sequence give no word unless they end the string.
// Reset clears the sequence state and both valid flags. While the output word waits
// untaken, the byte in the input register holds, even one that gives no word, and
// s_axis_tready stays low while both registers are full and the word is not taken.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	output logic s_axis_tready,
	input wire [7:0] s_axis_tdata,   // byte_in[7:0]
	input wire s_axis_tlast,         // last_byte
	output logic m_axis_tvalid,
	input wire m_axis_tready,
	output logic [23:0] m_axis_tdata, // code_point[20:0], then three zero bits
	output logic m_axis_tuser,       // replaced
	output logic m_axis_tlast        // end_of_string
);

	// Input register stage.
	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	// Sequence state: bytes still expected and payload collected so far.
	u8dec_pkg::u8dec_state_t state_q;
	u8dec_pkg::u8dec_state_t state_next;
	u8dec_pkg::u8dec_res_t res;

	logic out_free;
	logic advance;

	// The byte in stage one moves on whenever the output register can take
	// a result, whether or not this byte produces one.
	assign advance = out_free;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	u8dec_decode u_decode (
		.state(state_q),
		.byte_in(byte_s1),
		.last_byte(last_s1),
		.state_next(state_next),
		.res(res)
	);

	// The state advances once per byte, when the byte leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_next;
		end
	end

	u8dec_outreg u_outreg (
		.clk(clk),
		.arst_n(arst_n),
		.load(valid_s1 && res.valid),
		.res(res),
		.free(out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// A replacement word always carries U+FFFD.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[20:0] == u8dec_pkg::CpReplacement))
		else $error("replacement word without U+FFFD");

	// The last byte of a string always leaves no sequence open.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1) |=> (state_q.rem == '0))
		else $error("sequence still open after last byte");

	// The last byte of a string always produces a word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1) |-> res.valid)
		else $error("last byte gave no word");

	// Input stalls only behind a full, unaccepted output word.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

endmodule
`default_nettype wire

### sim/utf8_stream_decoder_tb.sv
// Self-checking testbench of the UTF-8 stream decoder with random flow control.
`timescale 1ns / 1ps
module utf8_stream_decoder_tb;

	localparam int unsigned RandomBytes = 800;
	localparam int unsigned WordGapMax = 7;
	localparam int unsigned LongHoldCycles = 400;
	localparam int unsigned LongHoldAt = 150;
	localparam int unsigned WatchdogLimit = 4000;
	localparam int unsigned ReportLimit = 10;

	// One byte of the input stream, with the idle cycles placed in front of it.
	typedef struct {
		logic [7:0] octet;
		logic is_last;
		int unsigned gap;
		bit drain;
	} byte_item_t;

	typedef struct packed {
		logic [u8dec_pkg::CpWidth-1:0] cp;
		logic rep;
		logic eos;
	} cp_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	utf8_stream_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	byte_item_t byte_queue[$];
	cp_word_t cp_queue[$];

	// Decoder state as the testbench sees it.
	logic [u8dec_pkg::RemWidth-1:0] seq_left = '0;
	logic [u8dec_pkg::CpWidth-1:0] seq_acc = '0;

	int unsigned errors = 0;
	int unsigned cps_checked = 0;
	int unsigned cps_replaced = 0;
	int unsigned strings_done = 0;
	int unsigned bytes_taken = 0;
	int unsigned idle_cycles = 0;

	// Generation controls: a burst string carries no gaps, a drain string waits
	// until every outstanding code point has been taken.
	bit burst_mode = 1'b0;
	bit drain_next = 1'b0;

	// Runs one byte through the decoder state; returns 1 when it yields a code point.
	function automatic bit decode_byte(input logic [7:0] b, input logic is_last,
			output cp_word_t w);
		w = '0;
		w.eos = is_last;
		if (seq_left == '0) begin
			if ((b & u8dec_pkg::Lead1Mask) == u8dec_pkg::Lead1Pat) begin
				w.cp = u8dec_pkg::CpWidth'(b);
				return 1'b1;
			end
			if ((b & u8dec_pkg::Lead2Mask) == u8dec_pkg::Lead2Pat) begin
				seq_acc = u8dec_pkg::CpWidth'(b & u8dec_pkg::Pay2Mask);
				seq_left = 2'd1;
			end else if ((b & u8dec_pkg::Lead3Mask) == u8dec_pkg::Lead3Pat) begin
				seq_acc = u8dec_pkg::CpWidth'(b & u8dec_pkg::Pay3Mask);
				seq_left = 2'd2;
			end else if ((b & u8dec_pkg::Lead4Mask) == u8dec_pkg::Lead4Pat) begin
				seq_acc = u8dec_pkg::CpWidth'(b & u8dec_pkg::Pay4Mask);
				seq_left = 2'd3;
			end else begin
				// Stray following byte or 11111xxx: replaced, byte consumed.
				w.cp = u8dec_pkg::CpReplacement;
				w.rep = 1'b1;
				return 1'b1;
			end
			if (is_last) begin
				// The string ends right on a multi-byte lead.
				seq_left = '0;
				seq_acc = '0;
				w.cp = u8dec_pkg::CpReplacement;
				w.rep = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		// Following bytes are taken as they are; only the low six bits count.
		seq_acc = (seq_acc << 6) | u8dec_pkg::CpWidth'(b & u8dec_pkg::ContMask);
		seq_left = seq_left - 2'd1;
		if (seq_left == '0) begin
			w.cp = seq_acc;
			seq_acc = '0;
			return 1'b1;
		end
		if (is_last) begin
			seq_left = '0;
			seq_acc = '0;
			w.cp = u8dec_pkg::CpReplacement;
			w.rep = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= ReportLimit)
			$display("%0t ERROR: %s", $realtime, msg);
	endtask

	// Queues a run of bytes; the final one carries the last-byte flag when asked.
	task automatic push_bytes(input logic [7:0] seq[$], input bit ends);
		byte_item_t it;
		for (int i = 0; i < seq.size(); i++) begin
			it.octet = seq[i];
			it.is_last = ends && (i == seq.size() - 1);
			it.gap = burst_mode ? 0 : $urandom_range(0, WordGapMax);
			it.drain = drain_next && (i == 0);
			byte_queue.push_back(it);
		end
		drain_next = 1'b0;
	endtask

	// Appends a lead byte of the given length with random payload bits.
	task automatic add_lead(inout logic [7:0] seq[$], input int unsigned len);
		case (len)
			1: seq.push_back(8'($urandom_range(0, 8'h7F)));
			2: seq.push_back(u8dec_pkg::Lead2Pat | 8'($urandom_range(0, 8'h1F)));
			3: seq.push_back(u8dec_pkg::Lead3Pat | 8'($urandom_range(0, 8'h0F)));
			default: seq.push_back(u8dec_pkg::Lead4Pat | 8'($urandom_range(0, 8'h07)));
		endcase
	endtask

	task automatic add_following(inout logic [7:0] seq[$], input int unsigned count);
		for (int i = 0; i < count; i++)
			seq.push_back(8'h80 | 8'($urandom_range(0, 8'h3F)));
	endtask

	// Random string: mostly well-formed characters of any length, with some
	// noise bytes, cut sequences and following bytes of the wrong pattern.
	task automatic gen_string();
		logic [7:0] seq[$];
		int unsigned nchars;
		int unsigned kind;
		int unsigned len;
		nchars = $urandom_range(1, 8);
		for (int c = 0; c < nchars; c++) begin
			kind = $urandom_range(0, 19);
			len = $urandom_range(1, 4);
			if (kind < 14) begin
				add_lead(seq, len);
				add_following(seq, len - 1);
			end else if (kind < 17) begin
				seq.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 19) begin
				add_lead(seq, (len < 2) ? 2 : len);
				add_following(seq, $urandom_range(0, ((len < 2) ? 2 : len) - 2));
			end else begin
				add_lead(seq, 2);
				seq.push_back(8'($urandom_range(0, 255)));
			end
		end
		// Now and then the string stops in the middle of a sequence.
		if ($urandom_range(0, 7) == 0) begin
			len = $urandom_range(2, 4);
			add_lead(seq, len);
			add_following(seq, $urandom_range(0, len - 2));
		end
		burst_mode = ($urandom_range(0, 3) == 0);
		push_bytes(seq, 1'b1);
	endtask

	// Driver: offers the head of the byte queue after its gap and holds it
	// while the decoder stalls.
	always @(posedge clk) begin : drive_bytes
		byte_item_t head;
		int unsigned gap_count;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_count = 0;
		end else if (s_axis_tvalid && !s_axis_tready) begin
			// Word still on offer; keep it stable.
		end else if (byte_queue.size() == 0) begin
			s_axis_tvalid <= 1'b0;
		end else if (gap_count < byte_queue[0].gap) begin
			s_axis_tvalid <= 1'b0;
			gap_count++;
		end else if (byte_queue[0].drain && (s_axis_tvalid || cp_queue.size() != 0)) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			head = byte_queue.pop_front();
			s_axis_tdata <= head.octet;
			s_axis_tlast <= head.is_last;
			s_axis_tvalid <= 1'b1;
			gap_count = 0;
		end
	end

	// Receiver: holds off for a random gap up to WordGapMax after each word, with calm
	// stretches, and one long hold-off that backs the decoder up into its input.
	always @(posedge clk) begin : take_words
		int unsigned words_taken;
		int unsigned hold_left;
		bit rx_calm;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			words_taken = 0;
			hold_left = 0;
			rx_calm = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				words_taken++;
				if (words_taken % 64 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				if (words_taken == LongHoldAt)
					hold_left = LongHoldCycles;
				else
					hold_left = rx_calm ? 0 : $urandom_range(0, WordGapMax);
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor: checks each output word against the oldest expected code point,
	// then predicts from the byte taken at this edge.
	always @(posedge clk) begin : check_words
		cp_word_t got;
		cp_word_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.cp = m_axis_tdata[u8dec_pkg::CpWidth-1:0];
				got.rep = m_axis_tuser;
				got.eos = m_axis_tlast;
				if (cp_queue.size() == 0) begin
					flag_error($sformatf("unexpected word cp=%06h rep=%0b eos=%0b",
						got.cp, got.rep, got.eos));
				end else begin
					want = cp_queue.pop_front();
					cps_checked++;
					if (want.rep)
						cps_replaced++;
					if (want.eos)
						strings_done++;
					if (got != want)
						flag_error($sformatf(
							"word %0d: expected cp=%06h rep=%0b eos=%0b, got cp=%06h rep=%0b eos=%0b",
							cps_checked, want.cp, want.rep, want.eos,
							got.cp, got.rep, got.eos));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				bytes_taken++;
				if (decode_byte(s_axis_tdata, s_axis_tlast, want))
					cp_queue.push_back(want);
			end
		end
	end

	// Watchdog: the run is stuck when no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("Timeout: no word moved for %0d cycles, %0d code points outstanding",
				idle_cycles, cp_queue.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [7:0] seq[$];
		int unsigned string_count;

		// Directed: ASCII extremes, stray following bytes, 11111xxx leads.
		seq = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF};
		push_bytes(seq, 1'b1);
		// Well-formed two-, three- and four-byte characters.
		seq = '{8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
		push_bytes(seq, 1'b0);
		// Largest value a four-byte lead can carry, ending the string.
		seq = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
		push_bytes(seq, 1'b1);
		// Following byte of the wrong pattern, still taken for its low bits.
		seq = '{8'hC3, 8'h41};
		push_bytes(seq, 1'b0);
		// String that ends on a lead byte, then one that ends mid-sequence.
		seq = '{8'hC3};
		push_bytes(seq, 1'b1);
		seq = '{8'hE2, 8'h82};
		push_bytes(seq, 1'b1);
		seq = '{8'h41};
		push_bytes(seq, 1'b1);

		string_count = 0;
		while (byte_queue.size() < RandomBytes + 25) begin
			// Two strings start only once the decoder has drained completely.
			if (string_count == 15 || string_count == 70)
				drain_next = 1'b1;
			gen_string();
			string_count++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || s_axis_tvalid || cp_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (cp_queue.size() != 0)
			flag_error($sformatf("%0d code points never arrived", cp_queue.size()));

		$display("Sent %0d bytes in %0d strings; checked %0d code points, %0d of them replaced.",
			bytes_taken, string_count + 5, cps_checked, cps_replaced);
		$display("Strings closed: %0d; mismatches: %0d.", strings_done, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
